// File: hw/rtl/lswc_pkg.sv
package lswc_pkg;

  // widest coordinate the package helpers handle
  localparam int CoordMax = 32;

  // clip steps before a segment is given up
  localparam int IterLimit = 8;

  // outcode bits
  localparam logic [3:0] CodeAbove = 4'd1;
  localparam logic [3:0] CodeBelow = 4'd2;
  localparam logic [3:0] CodeRight = 4'd4;
  localparam logic [3:0] CodeLeft  = 4'd8;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } reg_index_t;

  // window classification of one point; points on an edge are inside
  function automatic logic [3:0] outcode(
    input logic signed [CoordMax-1:0] x,
    input logic signed [CoordMax-1:0] y,
    input logic signed [CoordMax-1:0] lft,
    input logic signed [CoordMax-1:0] rgt,
    input logic signed [CoordMax-1:0] bot,
    input logic signed [CoordMax-1:0] tp
  );
    logic [3:0] c;
    c = 4'd0;
    if (x < lft) c = c | CodeLeft;
    if (x > rgt) c = c | CodeRight;
    if (y < bot) c = c | CodeBelow;
    if (y > tp)  c = c | CodeAbove;
    return c;
  endfunction

endpackage

// File: hw/rtl/lswc_front.sv
module lswc_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] left_edge,
  input  logic signed [COORD_WIDTH-1:0] right_edge,
  input  logic signed [COORD_WIDTH-1:0] bottom_edge,
  input  logic signed [COORD_WIDTH-1:0] top_edge,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [4*COORD_WIDTH+7:0]      push_data
);
  import lswc_pkg::*;

  logic                     vld;
  logic [4*COORD_WIDTH+7:0] data;
  logic [3:0]               c0;
  logic [3:0]               c1;

  assign in_ready   = !vld || push_ready;
  assign push_valid = vld;
  assign push_data  = data;

  always_comb begin
    c0 = outcode(CoordMax'(start_x), CoordMax'(start_y), CoordMax'(left_edge),
                 CoordMax'(right_edge), CoordMax'(bottom_edge), CoordMax'(top_edge));
    c1 = outcode(CoordMax'(end_x), CoordMax'(end_y), CoordMax'(left_edge),
                 CoordMax'(right_edge), CoordMax'(bottom_edge), CoordMax'(top_edge));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_valid && in_ready) begin
      data <= {start_x, start_y, end_x, end_y, c0, c1};
    end
  end

endmodule

// File: hw/rtl/lswc_queue.sv
module lswc_queue #(
  parameter int DATA_WIDTH = 72
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  push;
  logic                  pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/lswc_engine.sv
module lswc_engine #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [COORD_WIDTH-1:0] left_edge,
  input  logic signed [COORD_WIDTH-1:0] right_edge,
  input  logic signed [COORD_WIDTH-1:0] bottom_edge,
  input  logic signed [COORD_WIDTH-1:0] top_edge,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic [4*COORD_WIDTH+7:0]      pop_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          res_visible,
  output logic signed [COORD_WIDTH-1:0] res_start_x,
  output logic signed [COORD_WIDTH-1:0] res_start_y,
  output logic signed [COORD_WIDTH-1:0] res_end_x,
  output logic signed [COORD_WIDTH-1:0] res_end_y
);
  import lswc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W + 2;
  localparam int CW = $clog2(W + 2);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_MUL    = 6'b000100,
    S_DIV    = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [W-1:0] x0, y0, x1, y1;
  logic [3:0]          c0, c1;
  logic [3:0]          iter;
  logic                vis;
  logic                move_start;
  logic                fix_y;
  logic                neg;
  logic                db_zero;
  logic signed [W-1:0] a0;
  logic signed [W-1:0] edge_val;
  logic [W:0]          mag_da, mag_de, mag_db;
  logic [W:0]          rem;
  logic [W:0]          quo;
  logic [CW-1:0]       cnt;

  // decide-step selection
  logic [3:0]          c_sel;
  logic signed [W:0]   sa0, sa1, sb0, sb1, sed;
  logic signed [W:0]   da, de, db;
  logic signed [W-1:0] e_sel;
  logic                fy_sel;
  // divider step
  logic [W+1:0]        rem_sh;
  logic                q_bit;
  // update step
  logic signed [W+1:0] res_full;
  logic signed [W-1:0] res_val;
  logic signed [W-1:0] px, py;
  logic [3:0]          c_new;

  assign pop_ready   = state == S_IDLE;
  assign res_valid   = state == S_DONE;
  assign res_visible = vis;
  assign res_start_x = vis ? x0 : '0;
  assign res_start_y = vis ? y0 : '0;
  assign res_end_x   = vis ? x1 : '0;
  assign res_end_y   = vis ? y1 : '0;

  always_comb begin
    c_sel = (c0 != 4'd0) ? c0 : c1;
    if ((c_sel & CodeAbove) != 4'd0 || (c_sel & CodeBelow) != 4'd0) begin
      sa0    = x0;
      sa1    = x1;
      sb0    = y0;
      sb1    = y1;
      e_sel  = ((c_sel & CodeAbove) != 4'd0) ? top_edge : bottom_edge;
      fy_sel = 1'b1;
    end else begin
      sa0    = y0;
      sa1    = y1;
      sb0    = x0;
      sb1    = x1;
      e_sel  = ((c_sel & CodeRight) != 4'd0) ? right_edge : left_edge;
      fy_sel = 1'b0;
    end
    sed = e_sel;
    da  = sa1 - sa0;
    de  = sed - sb0;
    db  = sb1 - sb0;
  end

  // restoring divider: rem starts as the product's upper half, quo shifts
  // out the lower half and shifts in quotient bits
  always_comb begin
    rem_sh = {rem, quo[W]};
    q_bit  = rem_sh >= {1'b0, mag_db};
  end

  always_comb begin
    res_full = neg ? (W + 2)'(a0) - signed'({1'b0, quo}) : (W + 2)'(a0) + signed'({1'b0, quo});
    res_val  = db_zero ? a0 : res_full[W-1:0];
    px       = fix_y ? res_val : edge_val;
    py       = fix_y ? edge_val : res_val;
    c_new    = outcode(CoordMax'(px), CoordMax'(py), CoordMax'(left_edge),
                       CoordMax'(right_edge), CoordMax'(bottom_edge), CoordMax'(top_edge));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (pop_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        if ((c0 | c1) == 4'd0 || (c0 & c1) != 4'd0 || iter == 4'(IterLimit)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL:    state_next = S_DIV;
      S_DIV:    if (cnt == CW'(W)) state_next = S_UPDATE;
      S_UPDATE: state_next = S_DECIDE;
      S_DONE:   if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      S_IDLE: begin
        {x0, y0, x1, y1, c0, c1} <= pop_data;
        iter <= 4'd0;
      end
      S_DECIDE: begin
        vis        <= (c0 | c1) == 4'd0;
        move_start <= c0 != 4'd0;
        fix_y      <= fy_sel;
        edge_val   <= e_sel;
        a0         <= sa0[W-1:0];
        mag_da     <= da[W] ? -da : da;
        mag_de     <= de[W] ? -de : de;
        mag_db     <= db[W] ? -db : db;
        db_zero    <= db == '0;
        neg        <= (da[W] ^ de[W] ^ db[W]) && da != '0 && de != '0;
      end
      S_MUL: begin
        // product lands straight in the divider
        {rem, quo} <= PW'(mag_da) * PW'(mag_de);
        cnt        <= '0;
      end
      S_DIV: begin
        rem <= q_bit ? (W + 1)'(rem_sh - {1'b0, mag_db}) : rem_sh[W:0];
        quo <= {quo[W-1:0], q_bit};
        cnt <= cnt + 1'b1;
      end
      S_UPDATE: begin
        iter <= iter + 4'd1;
        if (move_start) begin
          x0 <= px;
          y0 <= py;
          c0 <= c_new;
        end else begin
          x1 <= px;
          y1 <= py;
          c1 <= c_new;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/line_segment_window_clipper_unit.sv
// line segment window clipper
//
// input channel in_valid / in_ready moves one word: a segment given by
// start_x, start_y, end_x, end_y. output channel out_valid / out_ready moves
// one word per segment: visible plus the clipped endpoints (all zero when
// the segment is rejected). the clip window sits in four registers written
// through cfg_valid / cfg_ready / cfg_index / cfg_data (0 left, 1 right,
// 2 bottom, 3 top); write them only while no segment is in flight.
//
// a front stage classifies each endpoint against the window, a two-entry
// queue decouples it from the clip engine, and an output register holds the
// finished word. each clip step (at most 8 per segment) in the engine is
// decide, one multiply, a restoring divider giving one quotient bit per
// cycle, and an update. the engine clips one segment at a time, so its
// divider sets the rate. reset empties the queue and output and restores
// the window to 100..500 on both axes. when the receiver stalls the output
// register holds its word and the queue fills, then in_ready drops.
module line_segment_window_clipper_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          visible,
  output logic signed [COORD_WIDTH-1:0] clip_start_x,
  output logic signed [COORD_WIDTH-1:0] clip_start_y,
  output logic signed [COORD_WIDTH-1:0] clip_end_x,
  output logic signed [COORD_WIDTH-1:0] clip_end_y
);
  import lswc_pkg::*;

  localparam int QW = 4 * COORD_WIDTH + 8;

  // window registers
  logic signed [COORD_WIDTH-1:0] left_edge;
  logic signed [COORD_WIDTH-1:0] right_edge;
  logic signed [COORD_WIDTH-1:0] bottom_edge;
  logic signed [COORD_WIDTH-1:0] top_edge;

  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  logic                          res_valid, res_ready, res_visible;
  logic signed [COORD_WIDTH-1:0] res_start_x, res_start_y, res_end_x, res_end_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge   <= COORD_WIDTH'(100);
      right_edge  <= COORD_WIDTH'(500);
      bottom_edge <= COORD_WIDTH'(100);
      top_edge    <= COORD_WIDTH'(500);
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_LEFT:   left_edge   <= cfg_data;
        REG_RIGHT:  right_edge  <= cfg_data;
        REG_BOTTOM: bottom_edge <= cfg_data;
        REG_TOP:    top_edge    <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: endpoint classification
  lswc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready,
    .start_x, .start_y, .end_x, .end_y,
    .left_edge, .right_edge, .bottom_edge, .top_edge,
    .push_valid, .push_ready, .push_data
  );

  // queue between classification and clipping
  lswc_queue #(.DATA_WIDTH(QW)) u_queue (
    .clk, .rst,
    .wr_valid(push_valid), .wr_ready(push_ready), .wr_data(push_data),
    .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_data(pop_data)
  );

  // back: iterative clip engine
  lswc_engine #(.COORD_WIDTH(COORD_WIDTH)) u_engine (
    .clk, .rst,
    .left_edge, .right_edge, .bottom_edge, .top_edge,
    .pop_valid, .pop_ready, .pop_data,
    .res_valid, .res_ready, .res_visible,
    .res_start_x, .res_start_y, .res_end_x, .res_end_y
  );

  // output register: takes a new word when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      visible      <= res_visible;
      clip_start_x <= res_start_x;
      clip_start_y <= res_start_y;
      clip_end_x   <= res_end_x;
      clip_end_y   <= res_end_y;
    end
  end

endmodule
